[hw/rtl/nt_arp_pkg.sv]
// Shared constants, types and codes of the note arpeggiator.
package nt_arp_pkg;

   localparam int MAX_KEYS    = 8;
   localparam int MAX_OCTAVES = 3;
   localparam int MAX_GATES   = 8;
   localparam int POOL_DEPTH  = MAX_KEYS * (MAX_OCTAVES + 1);

   localparam int FUNC_W  = 3;
   localparam int KEY_W   = 8;
   localparam int HFREQ_W = 24;
   localparam int STR_W   = 16;
   localparam int NOTE_W  = 8;
   localparam int OFREQ_W = 27;
   localparam int TAG_W   = 16;
   localparam int LEN_W   = 24;
   localparam int MODE_W  = 2;
   localparam int SPAN_W  = 2;
   localparam int CNT_W   = LEN_W + 1;

   localparam int KEY_IDX_W  = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
   localparam int KEY_CNT_W  = $clog2(MAX_KEYS + 1);
   localparam int POOL_IDX_W = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
   localparam int POOL_CNT_W = $clog2(POOL_DEPTH + 1);
   localparam int GATE_IDX_W = (MAX_GATES > 1) ? $clog2(MAX_GATES) : 1;
   localparam int GATE_CNT_W = $clog2(MAX_GATES + 1);
   localparam int OCT_W      = (MAX_OCTAVES > 0) ? $clog2(MAX_OCTAVES + 1) : 1;
   localparam int WIDE_W     = (HFREQ_W + MAX_OCTAVES > OFREQ_W) ?
                               HFREQ_W + MAX_OCTAVES : OFREQ_W;

   localparam logic [OFREQ_W-1:0] FREQ_MAX = {OFREQ_W{1'b1}};

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [1:0] REG_MODE = 2'd0;
   localparam logic [1:0] REG_SPAN = 2'd1;
   localparam logic [1:0] REG_STEP = 2'd2;
   localparam logic [1:0] REG_GATE = 2'd3;

   localparam logic [LEN_W-1:0] STEP_LEN_RESET = LEN_W'(6000);
   localparam logic [LEN_W-1:0] GATE_LEN_RESET = LEN_W'(3000);

   localparam logic [MODE_W-1:0] MODE_UP     = 2'd0;
   localparam logic [MODE_W-1:0] MODE_DOWN   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_UPDOWN = 2'd2;

   localparam logic EV_START = 1'b0;
   localparam logic EV_STOP  = 1'b1;

   typedef enum logic [FUNC_W-1:0] {
      FN_KEY_ON   = 3'd0,
      FN_KEY_OFF  = 3'd1,
      FN_PRESSURE = 3'd2,
      FN_TICK     = 3'd3,
      FN_CLEAR    = 3'd4
   } func_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_REBUILD,
      ST_TICK,
      ST_EVICT,
      ST_START,
      ST_GATE,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [SPAN_W-1:0] span;
      logic [LEN_W-1:0]  step_len;
      logic [LEN_W-1:0]  gate_len;
   } cfg_type;

   typedef struct packed {
      logic               kind;
      logic [TAG_W-1:0]   tag;
      logic [OFREQ_W-1:0] freq;
      logic [STR_W-1:0]   strength;
      logic [NOTE_W-1:0]  note;
   } event_type;

   typedef struct packed {
      logic      push;
      logic      flush;
      event_type ev;
   } emit_type;

   typedef struct packed {
      logic [GATE_CNT_W-1:0] gate_cnt;
      logic [KEY_CNT_W-1:0]  held_cnt;
   } status_type;

endpackage

[hw/rtl/nt_arp_if.sv]
// Request and result channel interfaces of the note arpeggiator.
interface nt_arp_req_if import nt_arp_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [FUNC_W-1:0]  func;
   logic [KEY_W-1:0]   key_id;
   logic [HFREQ_W-1:0] pitch_freq;
   logic [STR_W-1:0]   strength;
   logic [NOTE_W-1:0]  note_number;

   modport source(output valid, func, key_id, pitch_freq, strength, note_number,
                  input ready);
   modport sink(input valid, func, key_id, pitch_freq, strength, note_number,
                output ready);
endinterface

interface nt_arp_rsp_if import nt_arp_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               event_kind;
   logic [TAG_W-1:0]   voice_tag;
   logic [OFREQ_W-1:0] out_freq;
   logic [STR_W-1:0]   out_strength;
   logic [NOTE_W-1:0]  out_note;
   logic               last;

   modport source(output valid, event_kind, voice_tag, out_freq, out_strength, out_note,
                  last, input ready);
   modport sink(input valid, event_kind, voice_tag, out_freq, out_strength, out_note,
                last, output ready);
endinterface

[hw/rtl/note_arpeggiator_unit.sv]
// Note arpeggiator top level.
// One request at a time. On key on and key off the step pool is rebuilt
// one entry per cycle by a single row of frequency comparators that
// inserts each note and octave copy in sorted place. Pressure, clear and
// unused codes finish in the decode state. A tick may start a step, with a
// stop evicted first when the gate table is full, and then counts the open
// gates down one per cycle while the result path can take their stops.
// Results leave through a one-deep hold stage and an output register, the
// final one of a tick carrying last.
module note_arpeggiator_unit import nt_arp_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   nt_arp_req_if.sink            req_chan,
   nt_arp_rsp_if.source          rsp_chan,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   cfg_type    cfg;
   emit_type   emit;
   logic       emit_ok;
   status_type status;

   nt_arp_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   nt_arp_core u_core (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .req_chan (req_chan),
      .emit     (emit),
      .emit_ok  (emit_ok),
      .status   (status)
   );

   nt_arp_outbuf u_outbuf (
      .clock    (clock),
      .reset    (reset),
      .emit     (emit),
      .emit_ok  (emit_ok),
      .rsp_chan (rsp_chan)
   );

`ifndef SYNTHESIS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("ready stayed high after a request");

   a_push_flush_excl: assert property (@(posedge clock) disable iff (reset)
      !(emit.push && emit.flush))
      else $error("push and flush together");

   a_gate_bound: assert property (@(posedge clock) disable iff (reset)
      (status.gate_cnt <= GATE_CNT_W'(MAX_GATES)) && (status.held_cnt <= KEY_CNT_W'(MAX_KEYS)))
      else $error("table count out of range");
`endif

endmodule

[hw/rtl/nt_arp_csr.sv]
// Configuration registers behind the APB-style port.
module nt_arp_csr import nt_arp_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   cfg_type    cfg_ff, cfg_in;
   logic [1:0] idx;
   logic       wr;

   assign idx    = paddr[CSR_ADDR_W-1:2];
   assign wr     = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         unique case (idx)
            REG_MODE: cfg_in.mode     = pwdata[MODE_W-1:0];
            REG_SPAN: cfg_in.span     = pwdata[SPAN_W-1:0];
            REG_STEP: cfg_in.step_len = pwdata[LEN_W-1:0];
            REG_GATE: cfg_in.gate_len = pwdata[LEN_W-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_MODE: prdata = CSR_DATA_W'(cfg_ff.mode);
         REG_SPAN: prdata = CSR_DATA_W'(cfg_ff.span);
         REG_STEP: prdata = CSR_DATA_W'(cfg_ff.step_len);
         REG_GATE: prdata = CSR_DATA_W'(cfg_ff.gate_len);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode     <= MODE_UP;
         cfg_ff.span     <= '0;
         cfg_ff.step_len <= STEP_LEN_RESET;
         cfg_ff.gate_len <= GATE_LEN_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[hw/rtl/nt_arp_outbuf.sv]
// Result buffer: one held result plus the output register, marks the last result.
module nt_arp_outbuf import nt_arp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  emit_type   emit,
   output logic       emit_ok,
   nt_arp_rsp_if.source rsp_chan
);

   event_type hold_ff, hold_in;
   logic      hold_v_ff, hold_v_in;
   event_type out_ff, out_in;
   logic      out_v_ff, out_v_in;
   logic      last_ff, last_in;

   assign emit_ok = !hold_v_ff || !out_v_ff || rsp_chan.ready;

   always_comb begin
      hold_in   = hold_ff;
      hold_v_in = hold_v_ff;
      out_in    = out_ff;
      last_in   = last_ff;
      out_v_in  = out_v_ff && !rsp_chan.ready;
      if (emit.push && emit_ok) begin
         if (hold_v_ff) begin
            out_in   = hold_ff;
            last_in  = 1'b0;
            out_v_in = 1'b1;
         end
         hold_in   = emit.ev;
         hold_v_in = 1'b1;
      end else if (emit.flush && emit_ok && hold_v_ff) begin
         out_in    = hold_ff;
         last_in   = 1'b1;
         out_v_in  = 1'b1;
         hold_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_v_ff <= 1'b0;
         out_v_ff  <= 1'b0;
      end else begin
         hold_v_ff <= hold_v_in;
         out_v_ff  <= out_v_in;
      end
      hold_ff <= hold_in;
      out_ff  <= out_in;
      last_ff <= last_in;
   end

   assign rsp_chan.valid        = out_v_ff;
   assign rsp_chan.event_kind   = out_ff.kind;
   assign rsp_chan.voice_tag    = out_ff.tag;
   assign rsp_chan.out_freq     = out_ff.freq;
   assign rsp_chan.out_strength = out_ff.strength;
   assign rsp_chan.out_note     = out_ff.note;
   assign rsp_chan.last         = last_ff;

endmodule

[hw/rtl/nt_arp_core.sv]
// Sequencer with key table, sorted step pool and gate table.
module nt_arp_core import nt_arp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   nt_arp_req_if.sink req_chan,
   output emit_type   emit,
   input  logic       emit_ok,
   output status_type status
);

   state_type state_ff, state_in;
   func_type  func_ff, func_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic [HFREQ_W-1:0] freq_ff, freq_in;
   logic [STR_W-1:0]   str_ff, str_in;
   logic [NOTE_W-1:0]  note_ff, note_in;

   logic [KEY_W-1:0]   held_key_ff[MAX_KEYS], held_key_in[MAX_KEYS];
   logic [HFREQ_W-1:0] held_freq_ff[MAX_KEYS], held_freq_in[MAX_KEYS];
   logic [STR_W-1:0]   held_str_ff[MAX_KEYS], held_str_in[MAX_KEYS];
   logic [NOTE_W-1:0]  held_note_ff[MAX_KEYS], held_note_in[MAX_KEYS];
   logic [KEY_CNT_W-1:0] held_cnt_ff, held_cnt_in;

   logic [OFREQ_W-1:0] pool_freq_ff[POOL_DEPTH], pool_freq_in[POOL_DEPTH];
   logic [STR_W-1:0]   pool_str_ff[POOL_DEPTH], pool_str_in[POOL_DEPTH];
   logic [NOTE_W-1:0]  pool_note_ff[POOL_DEPTH], pool_note_in[POOL_DEPTH];
   logic [POOL_CNT_W-1:0] pool_cnt_ff, pool_cnt_in;

   logic                  started_ff, started_in;
   logic [POOL_IDX_W-1:0] pos_ff, pos_in;
   logic                  down_ff, down_in;
   logic [CNT_W-1:0]      countdown_ff, countdown_in;
   logic [TAG_W-1:0]      voice_ff, voice_in;

   logic [TAG_W-1:0] gate_voice_ff[MAX_GATES], gate_voice_in[MAX_GATES];
   logic [LEN_W-1:0] gate_rem_ff[MAX_GATES], gate_rem_in[MAX_GATES];
   logic [GATE_CNT_W-1:0] gate_cnt_ff, gate_cnt_in;

   logic [KEY_CNT_W-1:0]  ki_ff, ki_in;
   logic [OCT_W-1:0]      oi_ff, oi_in;
   logic                  first_key_ff, first_key_in;
   logic [GATE_CNT_W-1:0] gi_ff, gi_in;
   logic [GATE_CNT_W-1:0] gw_ff, gw_in;

   logic                 found;
   logic [KEY_IDX_W-1:0] found_idx;
   logic [OCT_W-1:0]     span_eff;
   logic [WIDE_W-1:0]    wide;
   logic [OFREQ_W-1:0]   ins_freq;
   logic [KEY_IDX_W-1:0] ki_idx;
   logic                 gt[POOL_DEPTH];
   logic [POOL_IDX_W-1:0] last_idx;
   logic [CNT_W-1:0]     step_m1;
   logic                 expired;
   logic [GATE_IDX_W-1:0] gi_idx;
   logic [LEN_W-1:0]     rem_next;

   always_comb begin
      found     = 1'b0;
      found_idx = '0;
      for (int i = MAX_KEYS - 1; i >= 0; i--) begin
         if ((KEY_CNT_W'(i) < held_cnt_ff) && (held_key_ff[i] == key_ff)) begin
            found     = 1'b1;
            found_idx = KEY_IDX_W'(i);
         end
      end
   end

   assign span_eff = (cfg.span > SPAN_W'(MAX_OCTAVES)) ? OCT_W'(MAX_OCTAVES) : OCT_W'(cfg.span);
   assign ki_idx   = ki_ff[KEY_IDX_W-1:0];
   assign wide     = WIDE_W'(held_freq_ff[ki_idx]) << oi_ff;
   assign ins_freq = (wide > WIDE_W'(FREQ_MAX)) ? FREQ_MAX : wide[OFREQ_W-1:0];

   always_comb begin
      for (int j = 0; j < POOL_DEPTH; j++) begin
         gt[j] = (POOL_CNT_W'(j) < pool_cnt_ff) && (pool_freq_ff[j] > ins_freq);
      end
   end

   assign last_idx = POOL_IDX_W'(pool_cnt_ff - 1'b1);
   assign step_m1  = CNT_W'({1'b0, cfg.step_len}) - CNT_W'(1);
   assign expired  = countdown_ff[CNT_W-1] || (countdown_ff == '0);
   assign gi_idx   = gi_ff[GATE_IDX_W-1:0];
   assign rem_next = (gate_rem_ff[gi_idx] != '0) ? LEN_W'(gate_rem_ff[gi_idx] - 1'b1) : '0;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign status.gate_cnt = gate_cnt_ff;
   assign status.held_cnt = held_cnt_ff;

   always_comb begin
      state_in     = state_ff;
      func_in      = func_ff;
      key_in       = key_ff;
      freq_in      = freq_ff;
      str_in       = str_ff;
      note_in      = note_ff;
      held_key_in  = held_key_ff;
      held_freq_in = held_freq_ff;
      held_str_in  = held_str_ff;
      held_note_in = held_note_ff;
      held_cnt_in  = held_cnt_ff;
      pool_freq_in = pool_freq_ff;
      pool_str_in  = pool_str_ff;
      pool_note_in = pool_note_ff;
      pool_cnt_in  = pool_cnt_ff;
      started_in   = started_ff;
      pos_in       = pos_ff;
      down_in      = down_ff;
      countdown_in = countdown_ff;
      voice_in     = voice_ff;
      gate_voice_in = gate_voice_ff;
      gate_rem_in  = gate_rem_ff;
      gate_cnt_in  = gate_cnt_ff;
      ki_in        = ki_ff;
      oi_in        = oi_ff;
      first_key_in = first_key_ff;
      gi_in        = gi_ff;
      gw_in        = gw_ff;
      emit         = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               func_in  = func_type'(req_chan.func);
               key_in   = req_chan.key_id;
               freq_in  = req_chan.pitch_freq;
               str_in   = req_chan.strength;
               note_in  = req_chan.note_number;
               state_in = ST_DECODE;
            end
         end

         ST_DECODE: begin
            state_in = ST_IDLE;
            ki_in    = '0;
            oi_in    = '0;
            unique case (func_ff)
               FN_KEY_ON: begin
                  first_key_in = (held_cnt_ff == '0);
                  if (found) begin
                     held_freq_in[found_idx] = freq_ff;
                     held_str_in[found_idx]  = str_ff;
                     held_note_in[found_idx] = note_ff;
                  end else if (held_cnt_ff < KEY_CNT_W'(MAX_KEYS)) begin
                     held_key_in[held_cnt_ff[KEY_IDX_W-1:0]]  = key_ff;
                     held_freq_in[held_cnt_ff[KEY_IDX_W-1:0]] = freq_ff;
                     held_str_in[held_cnt_ff[KEY_IDX_W-1:0]]  = str_ff;
                     held_note_in[held_cnt_ff[KEY_IDX_W-1:0]] = note_ff;
                     held_cnt_in = KEY_CNT_W'(held_cnt_ff + 1'b1);
                  end
                  pool_cnt_in = '0;
                  state_in    = ST_REBUILD;
               end
               FN_KEY_OFF: begin
                  first_key_in = 1'b0;
                  if (found) begin
                     for (int i = 0; i < MAX_KEYS - 1; i++) begin
                        if (KEY_IDX_W'(i) >= found_idx) begin
                           held_key_in[i]  = held_key_ff[i+1];
                           held_freq_in[i] = held_freq_ff[i+1];
                           held_str_in[i]  = held_str_ff[i+1];
                           held_note_in[i] = held_note_ff[i+1];
                        end
                     end
                     held_cnt_in = KEY_CNT_W'(held_cnt_ff - 1'b1);
                  end
                  pool_cnt_in = '0;
                  state_in    = ST_REBUILD;
               end
               FN_PRESSURE: begin
                  if (found) begin
                     held_str_in[found_idx] = str_ff;
                  end
               end
               FN_TICK: state_in = ST_TICK;
               FN_CLEAR: begin
                  held_cnt_in  = '0;
                  pool_cnt_in  = '0;
                  gate_cnt_in  = '0;
                  started_in   = 1'b0;
                  countdown_in = '0;
               end
               default: state_in = ST_IDLE;
            endcase
         end

         ST_REBUILD: begin
            if (ki_ff < held_cnt_ff) begin
               for (int j = 0; j < POOL_DEPTH; j++) begin
                  if ((j > 0) && gt[(j > 0) ? j - 1 : 0]) begin
                     pool_freq_in[j] = pool_freq_ff[(j > 0) ? j - 1 : 0];
                     pool_str_in[j]  = pool_str_ff[(j > 0) ? j - 1 : 0];
                     pool_note_in[j] = pool_note_ff[(j > 0) ? j - 1 : 0];
                  end else if (gt[j] || (POOL_CNT_W'(j) == pool_cnt_ff)) begin
                     pool_freq_in[j] = ins_freq;
                     pool_str_in[j]  = held_str_ff[ki_idx];
                     pool_note_in[j] = held_note_ff[ki_idx];
                  end
               end
               pool_cnt_in = POOL_CNT_W'(pool_cnt_ff + 1'b1);
               if (oi_ff == span_eff) begin
                  oi_in = '0;
                  ki_in = KEY_CNT_W'(ki_ff + 1'b1);
               end else begin
                  oi_in = OCT_W'(oi_ff + 1'b1);
               end
            end else begin
               if (pool_cnt_ff == '0) begin
                  started_in = 1'b0;
               end else if (started_ff && ({1'b0, pos_ff} >= pool_cnt_ff)) begin
                  pos_in = last_idx;
               end
               if (first_key_ff) begin
                  started_in   = 1'b0;
                  countdown_in = '0;
               end
               state_in = ST_IDLE;
            end
         end

         ST_TICK: begin
            gi_in    = '0;
            gw_in    = '0;
            state_in = ST_GATE;
            if (held_cnt_ff != '0) begin
               if (!started_ff || expired) begin
                  countdown_in = step_m1;
                  if (pool_cnt_ff != '0) begin
                     started_in = 1'b1;
                     if (!started_ff) begin
                        if (cfg.mode == MODE_DOWN) begin
                           pos_in  = last_idx;
                           down_in = 1'b1;
                        end else begin
                           pos_in  = '0;
                           down_in = 1'b0;
                        end
                     end else if (pool_cnt_ff <= POOL_CNT_W'(1)) begin
                        pos_in = '0;
                     end else if (cfg.mode == MODE_DOWN) begin
                        pos_in = (pos_ff == '0) ? last_idx : POOL_IDX_W'(pos_ff - 1'b1);
                     end else if (cfg.mode == MODE_UPDOWN) begin
                        if (down_ff) begin
                           if (pos_ff == '0) begin
                              pos_in  = POOL_IDX_W'(1);
                              down_in = 1'b0;
                           end else begin
                              pos_in = POOL_IDX_W'(pos_ff - 1'b1);
                           end
                        end else if ({1'b0, pos_ff} >= POOL_CNT_W'(pool_cnt_ff - 1'b1)) begin
                           pos_in  = POOL_IDX_W'(pool_cnt_ff - 2'd2);
                           down_in = 1'b1;
                        end else begin
                           pos_in = POOL_IDX_W'(pos_ff + 1'b1);
                        end
                     end else begin
                        pos_in = ({1'b0, pos_ff} >= POOL_CNT_W'(pool_cnt_ff - 1'b1)) ?
                                 '0 : POOL_IDX_W'(pos_ff + 1'b1);
                     end
                     state_in = (gate_cnt_ff >= GATE_CNT_W'(MAX_GATES)) ? ST_EVICT : ST_START;
                  end
               end else begin
                  countdown_in = CNT_W'(countdown_ff - 1'b1);
               end
            end
         end

         ST_EVICT: begin
            emit.push    = 1'b1;
            emit.ev.kind = EV_STOP;
            emit.ev.tag  = gate_voice_ff[0];
            if (emit_ok) begin
               for (int i = 0; i < MAX_GATES - 1; i++) begin
                  gate_voice_in[i] = gate_voice_ff[i+1];
                  gate_rem_in[i]   = gate_rem_ff[i+1];
               end
               gate_cnt_in = GATE_CNT_W'(gate_cnt_ff - 1'b1);
               state_in    = ST_START;
            end
         end

         ST_START: begin
            emit.push        = 1'b1;
            emit.ev.kind     = EV_START;
            emit.ev.tag      = voice_ff;
            emit.ev.freq     = pool_freq_ff[pos_ff];
            emit.ev.strength = pool_str_ff[pos_ff];
            emit.ev.note     = pool_note_ff[pos_ff];
            if (emit_ok) begin
               voice_in = TAG_W'(voice_ff + 1'b1);
               gate_voice_in[gate_cnt_ff[GATE_IDX_W-1:0]] = voice_ff;
               gate_rem_in[gate_cnt_ff[GATE_IDX_W-1:0]]   = cfg.gate_len;
               gate_cnt_in = GATE_CNT_W'(gate_cnt_ff + 1'b1);
               state_in    = ST_GATE;
            end
         end

         ST_GATE: begin
            if (gi_ff == gate_cnt_ff) begin
               gate_cnt_in = gw_ff;
               state_in    = ST_FLUSH;
            end else if (rem_next == '0) begin
               emit.push    = 1'b1;
               emit.ev.kind = EV_STOP;
               emit.ev.tag  = gate_voice_ff[gi_idx];
               if (emit_ok) begin
                  gi_in = GATE_CNT_W'(gi_ff + 1'b1);
               end
            end else begin
               gate_voice_in[gw_ff[GATE_IDX_W-1:0]] = gate_voice_ff[gi_idx];
               gate_rem_in[gw_ff[GATE_IDX_W-1:0]]   = rem_next;
               gw_in = GATE_CNT_W'(gw_ff + 1'b1);
               gi_in = GATE_CNT_W'(gi_ff + 1'b1);
            end
         end

         ST_FLUSH: begin
            emit.flush = 1'b1;
            if (emit_ok) begin
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         held_cnt_ff  <= '0;
         pool_cnt_ff  <= '0;
         started_ff   <= 1'b0;
         down_ff      <= 1'b0;
         countdown_ff <= '0;
         voice_ff     <= '0;
         gate_cnt_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         held_cnt_ff  <= held_cnt_in;
         pool_cnt_ff  <= pool_cnt_in;
         started_ff   <= started_in;
         down_ff      <= down_in;
         countdown_ff <= countdown_in;
         voice_ff     <= voice_in;
         gate_cnt_ff  <= gate_cnt_in;
      end
      func_ff       <= func_in;
      key_ff        <= key_in;
      freq_ff       <= freq_in;
      str_ff        <= str_in;
      note_ff       <= note_in;
      held_key_ff   <= held_key_in;
      held_freq_ff  <= held_freq_in;
      held_str_ff   <= held_str_in;
      held_note_ff  <= held_note_in;
      pool_freq_ff  <= pool_freq_in;
      pool_str_ff   <= pool_str_in;
      pool_note_ff  <= pool_note_in;
      pos_ff        <= pos_in;
      gate_voice_ff <= gate_voice_in;
      gate_rem_ff   <= gate_rem_in;
      ki_ff         <= ki_in;
      oi_ff         <= oi_in;
      first_key_ff  <= first_key_in;
      gi_ff         <= gi_in;
      gw_ff         <= gw_in;
   end

endmodule

[tb/sv/tb.sv]
// Testbench for the note arpeggiator: random and directed requests checked against a predictor.
module tb;
   import nt_arp_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic pready;

   nt_arp_req_if req_chan ();
   nt_arp_rsp_if rsp_chan ();

   note_arpeggiator_unit dut (
      .clock(clock), .reset(reset), .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
      .prdata(prdata), .pready(pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   typedef struct packed {
      logic               kind;
      logic [TAG_W-1:0]   tag;
      logic [OFREQ_W-1:0] freq;
      logic [STR_W-1:0]   strength;
      logic [NOTE_W-1:0]  note;
      logic               last;
   } voice_event_t;

   voice_event_t event_queue[$];
   int  errors = 0;
   int  send_idle_pct = 0;
   int  recv_idle_pct = 0;
   bit  recv_hold = 1'b0;
   longint cycle_count = 0;

   // predictor state
   logic [MODE_W-1:0] p_mode;
   logic [SPAN_W-1:0] p_span;
   logic [LEN_W-1:0]  p_step_len, p_gate_len;
   logic [KEY_W-1:0]   h_key[MAX_KEYS];
   logic [HFREQ_W-1:0] h_freq[MAX_KEYS];
   logic [STR_W-1:0]   h_str[MAX_KEYS];
   logic [NOTE_W-1:0]  h_note[MAX_KEYS];
   int h_cnt;
   logic [OFREQ_W-1:0] pl_freq[POOL_DEPTH];
   logic [STR_W-1:0]   pl_str[POOL_DEPTH];
   logic [NOTE_W-1:0]  pl_note[POOL_DEPTH];
   int pl_cnt, s_pos, s_cnt;
   bit g_down;
   logic [TAG_W-1:0] v_ctr;
   logic [TAG_W-1:0] g_voice[MAX_GATES];
   int g_rem[MAX_GATES];
   int g_cnt;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 4000000) begin
         $display("simulation failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset)
         rsp_chan.ready <= 1'b0;
      else
         rsp_chan.ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      voice_event_t got, exp_ev;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got = {rsp_chan.event_kind, rsp_chan.voice_tag, rsp_chan.out_freq,
                rsp_chan.out_strength, rsp_chan.out_note, rsp_chan.last};
         if (event_queue.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, actual %h", $time, got);
         end else begin
            exp_ev = event_queue.pop_front();
            if (got !== exp_ev) begin
               errors++;
               $display("%0t: mismatch, expected kind %0d tag %0d freq %h str %h note %h last %0d",
                        $time, exp_ev.kind, exp_ev.tag, exp_ev.freq, exp_ev.strength,
                        exp_ev.note, exp_ev.last);
               $display("%0t:          actual kind %0d tag %0d freq %h str %h note %h last %0d",
                        $time, got.kind, got.tag, got.freq, got.strength, got.note, got.last);
            end
         end
      end
   end

   function automatic void predict_reset();
      p_mode = MODE_UP; p_span = '0;
      p_step_len = STEP_LEN_RESET; p_gate_len = GATE_LEN_RESET;
      h_cnt = 0; pl_cnt = 0; s_pos = -1; g_down = 0; s_cnt = 0; v_ctr = '0; g_cnt = 0;
   endfunction

   function automatic int find_held(logic [KEY_W-1:0] key);
      for (int i = 0; i < h_cnt; i++)
         if (h_key[i] == key) return i;
      return -1;
   endfunction

   function automatic void rebuild_pool();
      int n, j;
      logic [WIDE_W:0] wide;
      logic [OFREQ_W-1:0] fv;
      n = 0;
      for (int i = 0; i < h_cnt; i++) begin
         for (int o = 0; o <= p_span; o++) begin
            wide = {{(WIDE_W+1-HFREQ_W){1'b0}}, h_freq[i]} << o;
            fv = (wide > FREQ_MAX) ? FREQ_MAX : wide[OFREQ_W-1:0];
            j = n;
            while (j > 0 && pl_freq[j-1] > fv) begin
               pl_freq[j] = pl_freq[j-1]; pl_str[j] = pl_str[j-1]; pl_note[j] = pl_note[j-1];
               j--;
            end
            pl_freq[j] = fv; pl_str[j] = h_str[i]; pl_note[j] = h_note[i];
            n++;
         end
      end
      pl_cnt = n;
      if (n == 0) s_pos = -1;
      else if (s_pos >= n) s_pos = n - 1;
   endfunction

   function automatic void push_event(logic kind, logic [TAG_W-1:0] tag,
                                      logic [OFREQ_W-1:0] f, logic [STR_W-1:0] s,
                                      logic [NOTE_W-1:0] nt);
      event_queue = {event_queue, voice_event_t'({kind, tag, f, s, nt, 1'b0})};
   endfunction

   function automatic void start_step();
      int n;
      n = pl_cnt;
      if (n == 0) begin
         s_cnt = p_step_len;
         return;
      end
      if (s_pos < 0) begin
         if (p_mode == MODE_DOWN) begin s_pos = n - 1; g_down = 1; end
         else begin s_pos = 0; g_down = 0; end
      end else if (n <= 1) begin
         s_pos = 0;
      end else if (p_mode == MODE_DOWN) begin
         s_pos = (s_pos - 1 + n) % n;
      end else if (p_mode == MODE_UPDOWN) begin
         s_pos += g_down ? -1 : 1;
         if (s_pos >= n) begin s_pos = n - 2; g_down = 1; end
         else if (s_pos < 0) begin s_pos = 1; g_down = 0; end
      end else begin
         s_pos = (s_pos + 1) % n;
      end
      if (g_cnt >= MAX_GATES) begin
         push_event(EV_STOP, g_voice[0], '0, '0, '0);
         for (int i = 1; i < g_cnt; i++) begin
            g_voice[i-1] = g_voice[i]; g_rem[i-1] = g_rem[i];
         end
         g_cnt--;
      end
      push_event(EV_START, v_ctr, pl_freq[s_pos], pl_str[s_pos], pl_note[s_pos]);
      g_voice[g_cnt] = v_ctr;
      g_rem[g_cnt] = p_gate_len;
      g_cnt++;
      v_ctr++;
      s_cnt = p_step_len;
   endfunction

   function automatic void predict_request(logic [FUNC_W-1:0] fn, logic [KEY_W-1:0] key,
                                           logic [HFREQ_W-1:0] f, logic [STR_W-1:0] s,
                                           logic [NOTE_W-1:0] nt);
      int pos, w, before_cnt;
      bit first_key;
      case (fn)
         FN_KEY_ON: begin
            first_key = (h_cnt == 0);
            pos = find_held(key);
            if (pos >= 0) begin
               h_freq[pos] = f; h_str[pos] = s; h_note[pos] = nt;
            end else if (h_cnt < MAX_KEYS) begin
               h_key[h_cnt] = key; h_freq[h_cnt] = f; h_str[h_cnt] = s; h_note[h_cnt] = nt;
               h_cnt++;
            end
            rebuild_pool();
            if (first_key) begin s_pos = -1; s_cnt = 0; end
         end
         FN_KEY_OFF: begin
            pos = find_held(key);
            if (pos >= 0) begin
               for (int i = pos + 1; i < h_cnt; i++) begin
                  h_key[i-1] = h_key[i]; h_freq[i-1] = h_freq[i];
                  h_str[i-1] = h_str[i]; h_note[i-1] = h_note[i];
               end
               h_cnt--;
            end
            rebuild_pool();
         end
         FN_PRESSURE: begin
            pos = find_held(key);
            if (pos >= 0) h_str[pos] = s;
         end
         FN_TICK: begin
            before_cnt = event_queue.size();
            if (h_cnt > 0) begin
               if (s_pos < 0 || s_cnt <= 0) start_step();
               s_cnt -= 1;
            end
            for (int i = 0; i < g_cnt; i++)
               if (g_rem[i] > 0) g_rem[i] -= 1;
            w = 0;
            for (int i = 0; i < g_cnt; i++) begin
               if (g_rem[i] <= 0) begin
                  push_event(EV_STOP, g_voice[i], '0, '0, '0);
               end else begin
                  g_voice[w] = g_voice[i]; g_rem[w] = g_rem[i]; w++;
               end
            end
            g_cnt = w;
            if (event_queue.size() > before_cnt)
               event_queue[event_queue.size()-1].last = 1'b1;
         end
         FN_CLEAR: begin
            h_cnt = 0; pl_cnt = 0; g_cnt = 0; s_pos = -1; s_cnt = 0;
         end
         default: ;
      endcase
   endfunction

   task automatic send_request(logic [FUNC_W-1:0] fn, logic [KEY_W-1:0] key,
                               logic [HFREQ_W-1:0] f, logic [STR_W-1:0] s,
                               logic [NOTE_W-1:0] nt);
      while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      req_chan.valid <= 1'b1;
      req_chan.func <= fn; req_chan.key_id <= key; req_chan.pitch_freq <= f;
      req_chan.strength <= s; req_chan.note_number <= nt;
      do @(posedge clock); while (!req_chan.ready);
      predict_request(fn, key, f, s, nt);
      req_chan.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [CSR_DATA_W-1:0] value);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= CSR_ADDR_W'({idx, 2'b00}); pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      case (idx)
         REG_MODE: p_mode = value[MODE_W-1:0];
         REG_SPAN: p_span = value[SPAN_W-1:0];
         REG_STEP: p_step_len = value[LEN_W-1:0];
         default:  p_gate_len = value[LEN_W-1:0];
      endcase
      @(posedge clock);
   endtask

   task automatic drain();
      int guard;
      guard = 0;
      while (event_queue.size() != 0 && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
      repeat (120) @(posedge clock);
   endtask

   task automatic configure(int md, int sp, int st, int gt);
      drain();
      write_reg(REG_MODE, md);
      write_reg(REG_SPAN, sp);
      write_reg(REG_STEP, st);
      write_reg(REG_GATE, gt);
   endtask

   task automatic random_request(int key_range);
      int r;
      logic [FUNC_W-1:0] fn;
      r = $urandom_range(99);
      if (r < 55) fn = FN_TICK;
      else if (r < 75) fn = FN_KEY_ON;
      else if (r < 87) fn = FN_KEY_OFF;
      else if (r < 94) fn = FN_PRESSURE;
      else if (r < 96) fn = FN_CLEAR;
      else fn = FUNC_W'($urandom_range(7, 5));
      send_request(fn, (r & 1) ? KEY_W'($urandom_range(key_range)) : KEY_W'($urandom),
                   HFREQ_W'($urandom), STR_W'($urandom), NOTE_W'($urandom));
   endtask

   task automatic test_directed();
      configure(MODE_UP, 3, 0, 1);
      send_request(FN_TICK, 0, 0, 0, 0);
      send_request(FN_KEY_ON, 8'hFF, 24'hFFFFFF, 16'hFFFF, 8'hFF);
      send_request(FN_KEY_ON, 8'h00, 24'h000000, 16'h0000, 8'h00);
      send_request(FN_KEY_ON, 8'h10, 24'h000000, 16'h1234, 8'h55);
      send_request(FN_KEY_ON, 8'h10, 24'h400000, 16'h4321, 8'hAA);
      send_request(FN_PRESSURE, 8'h10, 0, 16'h7777, 0);
      send_request(FN_PRESSURE, 8'h99, 0, 16'h1111, 0);
      repeat (3) send_request(FN_TICK, 0, 0, 0, 0);
      for (int k = 1; k <= 9; k++)
         send_request(FN_KEY_ON, KEY_W'(32 + k), HFREQ_W'(k * 1000), STR_W'(k), NOTE_W'(k));
      send_request(FN_KEY_OFF, 8'h77, 0, 0, 0);
      send_request(FN_KEY_OFF, 8'hFF, 0, 0, 0);
      send_request(FUNC_W'(5), 0, 0, 0, 0);
      send_request(FUNC_W'(7), 0, 0, 0, 0);
      send_request(FN_TICK, 0, 0, 0, 0);
      send_request(FN_CLEAR, 0, 0, 0, 0);
      send_request(FN_TICK, 0, 0, 0, 0);
   endtask

   task automatic test_gate_eviction();
      configure(MODE_DOWN, 1, 1, 24'hFFFFFF);
      send_request(FN_KEY_ON, 1, 24'h001000, 16'hABCD, 60);
      send_request(FN_KEY_ON, 2, 24'h000800, 16'h1357, 62);
      repeat (12) send_request(FN_TICK, 0, 0, 0, 0);
      send_request(FN_CLEAR, 0, 0, 0, 0);
   endtask

   task automatic test_backpressure();
      configure(MODE_UP, 0, 0, 0);
      send_request(FN_KEY_ON, 3, 24'h000100, 16'h0101, 1);
      recv_hold = 1'b1;
      fork
         begin
            repeat (400) @(posedge clock);
            recv_hold = 1'b0;
         end
         repeat (10) send_request(FN_TICK, 0, 0, 0, 0);
      join
   endtask

   task automatic test_random_mode(int md, int sp, int st, int gt, int count);
      configure(md, sp, st, gt);
      repeat (count) random_request(15);
   endtask

   initial begin
      req_chan.valid = 1'b0;
      req_chan.func = FN_TICK; req_chan.key_id = '0; req_chan.pitch_freq = '0;
      req_chan.strength = '0; req_chan.note_number = '0;
      predict_reset();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 38; recv_idle_pct = 60;
      test_directed();
      test_gate_eviction();
      test_random_mode(MODE_UP, 0, 3, 5, 50);
      send_idle_pct = 60; recv_idle_pct = 38;
      test_backpressure();
      test_random_mode(MODE_DOWN, 2, 1, 9, 50);
      test_random_mode(MODE_UPDOWN, 3, 2, 4, 50);
      send_idle_pct = 0; recv_idle_pct = 0;
      test_random_mode(3, 1, 0, 1, 50);
      test_random_mode(MODE_UPDOWN, 3, 24'hFFFFFF, 24'hFFFFFF, 30);
      test_random_mode(MODE_UPDOWN, 2, 1, 30, 40);
      drain();

      if (event_queue.size() != 0) begin
         errors++;
         $display("%0t: missing results, expected %0d more, actual none",
                  $time, event_queue.size());
      end
      if (errors == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end
endmodule
